// ===== rtl/pnof_pkg.sv =====
// Shared sizes, codes and port structs of the Petri net omega firing block.
// Used by pnof_store and petri_net_omega_firing_top; it depends on nothing else.
package pnof_pkg;

    localparam int PLACE_COUNT     = 16;
    localparam int TRANS_COUNT     = 16;
    localparam int TOKEN_BITS      = 16;
    localparam int WEIGHT_BITS     = 8;
    localparam int MAX_RES         = 16;

    localparam int PLACE_W = (PLACE_COUNT > 1) ? $clog2(PLACE_COUNT) : 1;
    localparam int TRANS_W = (TRANS_COUNT > 1) ? $clog2(TRANS_COUNT) : 1;
    localparam int PCNT_W  = $clog2(PLACE_COUNT + 1);
    localparam int RES_W   = $clog2(MAX_RES + 1);
    localparam int SUM_W   = ((TOKEN_BITS > WEIGHT_BITS) ? TOKEN_BITS : WEIGHT_BITS) + 1;
    localparam int DIFF_W  = SUM_W + 1;

    localparam logic [TOKEN_BITS-1:0] TOK_MAX = '1;

    typedef enum logic [2:0] {
        KIND_PRE_WEIGHT  = 3'd0,
        KIND_POST_WEIGHT = 3'd1,
        KIND_SET_PLACE   = 3'd2,
        KIND_FIRE        = 3'd3,
        KIND_LIST        = 3'd4,
        KIND_READ_PLACE  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NOT_ENABLED  = 2'd1,
        STAT_NONE_ENABLED = 2'd2,
        STAT_SATURATED    = 2'd3
    } status_t;

    typedef struct packed {
        logic                  omega;
        logic [TOKEN_BITS-1:0] count;
    } mark_t;

    typedef struct packed {
        logic [PLACE_W-1:0] place;
        logic [TRANS_W-1:0] trans;
    } rd_req_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] pre;
        logic [WEIGHT_BITS-1:0] post;
        mark_t                  mark;
    } rd_rsp_t;

    typedef struct packed {
        logic                   pre_en;
        logic                   post_en;
        logic [PLACE_W-1:0]     place;
        logic [TRANS_W-1:0]     trans;
        logic [WEIGHT_BITS-1:0] data;
    } wt_wr_t;

    typedef struct packed {
        logic               en;
        logic [PLACE_W-1:0] place;
        mark_t              mark;
    } mk_wr_t;

endpackage

// ===== rtl/pnof_store.sv =====
// Weight tables and marking store with one registered read port each.
// After reset a clearing pass zeroes one entry per cycle while clr_busy is high.
// Depends on pnof_pkg.
module pnof_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  pnof_pkg::rd_req_t rd_req,
    input  pnof_pkg::wt_wr_t  wt_wr,
    input  pnof_pkg::mk_wr_t  mk_wr,
    output pnof_pkg::rd_rsp_t rd_rsp,
    output logic              clr_busy
);
    import pnof_pkg::*;

    logic [WEIGHT_BITS-1:0] pre_mem  [PLACE_COUNT][TRANS_COUNT];
    logic [WEIGHT_BITS-1:0] post_mem [PLACE_COUNT][TRANS_COUNT];
    mark_t                  mark_mem [PLACE_COUNT];

    logic [WEIGHT_BITS-1:0] pre_q_reg;
    logic [WEIGHT_BITS-1:0] post_q_reg;
    mark_t                  mark_q_reg;
    logic                   clr_busy_reg;
    logic [PLACE_W-1:0]     clr_p_reg;
    logic [TRANS_W-1:0]     clr_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_p_reg    <= '0;
            clr_t_reg    <= '0;
        end else if (clr_busy_reg) begin
            if (32'(clr_t_reg) == TRANS_COUNT - 1) begin
                clr_t_reg <= '0;
                if (32'(clr_p_reg) == PLACE_COUNT - 1) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_p_reg <= clr_p_reg + 1'b1;
                end
            end else begin
                clr_t_reg <= clr_t_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            pre_mem[clr_p_reg][clr_t_reg]  <= '0;
            post_mem[clr_p_reg][clr_t_reg] <= '0;
            mark_mem[clr_p_reg]            <= '0;
        end else begin
            if (wt_wr.pre_en) begin
                pre_mem[wt_wr.place][wt_wr.trans] <= wt_wr.data;
            end
            if (wt_wr.post_en) begin
                post_mem[wt_wr.place][wt_wr.trans] <= wt_wr.data;
            end
            if (mk_wr.en) begin
                mark_mem[mk_wr.place] <= mk_wr.mark;
            end
        end
        pre_q_reg  <= pre_mem[rd_req.place][rd_req.trans];
        post_q_reg <= post_mem[rd_req.place][rd_req.trans];
        mark_q_reg <= mark_mem[rd_req.place];
    end

    assign rd_rsp.pre  = pre_q_reg;
    assign rd_rsp.post = post_q_reg;
    assign rd_rsp.mark = mark_q_reg;
    assign clr_busy    = clr_busy_reg;

endmodule

// ===== rtl/petri_net_omega_firing_top.sv =====
// Top level of the Petri net firing engine with omega markings.
// Depends on pnof_pkg and pnof_store.
// Each input word carries one command: write a pre or post weight, set a
// place, fire a transition, list the enabled transitions, or read a place.
// Every command but the two unused kinds returns result words on the master
// side; a list returns one word per enabled transition, at most sixteen,
// or a single none-enabled word, with tlast on the final one. The single
// register selects omega propagation and is written through cfg_wr_en
// and cfg_wr_data. The block takes one command at a time and is ready
// only while idle. A weight write or set goes from idle to S_EMIT, which
// loads its result word into the output register; a read passes S_RDW
// first. A fire of a valid transition walks all places through the store
// in S_CHK and, if it is enabled, again in S_UPD, one place per cycle on
// a shared subtract and add unit. A list checks the transitions in order,
// each with a walk over all places in S_CHK followed by S_LNEXT.
// Reset sets omega propagation and starts a pass that clears the weights
// and marking, one entry per cycle, with s_tready low until it ends. A
// stalled receiver holds the block in its result state; the next command
// is taken once the last result word is in the output register.
module petri_net_omega_firing_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // place_index, trans_index, value, set_omega, zero pad
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // trans_out, tokens_out, omega_out, zero pad
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast
);
    import pnof_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_UPD,
        S_RDW,
        S_LNEXT,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic                  omega_prop_reg;
    logic                  fire_mode_reg, fire_mode_next;
    logic                  pl_ok_reg, pl_ok_next;
    logic [3:0]            tr_field_reg, tr_field_next;
    logic [TRANS_W-1:0]    t_reg, t_next;
    logic [PCNT_W-1:0]     cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic                  pend_last_reg, pend_last_next;
    logic [PLACE_W-1:0]    proc_p_reg, proc_p_next;
    logic                  fail_reg, fail_next;
    logic                  pomega_reg, pomega_next;
    logic                  sat_reg, sat_next;
    logic                  held_vld_reg, held_vld_next;
    logic [TRANS_W-1:0]    held_t_reg, held_t_next;
    logic [RES_W-1:0]      total_reg, total_next;
    logic                  fin_reg, fin_next;
    logic                  after_lnext_reg, after_lnext_next;

    status_t               res_status_reg, res_status_next;
    logic [3:0]            res_trans_reg, res_trans_next;
    logic [15:0]           res_tokens_reg, res_tokens_next;
    logic                  res_omega_reg, res_omega_next;
    logic                  res_last_reg, res_last_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    status_t               m_status_reg, m_status_next;
    logic [3:0]            m_trans_reg, m_trans_next;
    logic [15:0]           m_tokens_reg, m_tokens_next;
    logic                  m_omega_reg, m_omega_next;
    logic                  m_last_reg, m_last_next;

    logic [2:0]            s_kind;
    logic [3:0]            s_place;
    logic [3:0]            s_trans;
    logic [15:0]           s_value;
    logic                  s_som;
    logic                  s_pok;
    logic                  s_tok;
    logic                  set_sat;

    rd_req_t               rd_req;
    rd_rsp_t               rd_rsp;
    wt_wr_t                wt_wr;
    mk_wr_t                mk_wr;
    logic                  clr_busy;

    logic [DIFF_W-1:0]     diff;
    logic                  borrow;
    logic [SUM_W-1:0]      sum;
    logic                  sum_sat;
    logic                  issue;
    logic                  pass_end;
    logic                  place_fail;
    logic                  place_pom;
    logic                  enabled;
    logic                  prop;
    logic                  t_last;
    logic                  finish;

    assign s_kind  = s_tuser;
    assign s_place = s_tdata[3:0];
    assign s_trans = s_tdata[7:4];
    assign s_value = s_tdata[23:8];
    assign s_som   = s_tdata[24];
    assign s_pok   = 32'(s_place) < PLACE_COUNT;
    assign s_tok   = 32'(s_trans) < TRANS_COUNT;
    assign set_sat = 32'(s_value) > 32'(TOK_MAX);

    assign s_tready = (state_reg == S_IDLE) && !clr_busy;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_omega_reg, m_tokens_reg, m_trans_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    pnof_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_req   (rd_req),
        .wt_wr    (wt_wr),
        .mk_wr    (mk_wr),
        .rd_rsp   (rd_rsp),
        .clr_busy (clr_busy)
    );

    // Shared unit: count minus pre weight, then plus post weight.
    assign diff    = DIFF_W'(rd_rsp.mark.count) - DIFF_W'(rd_rsp.pre);
    assign borrow  = diff[DIFF_W-1];
    assign sum     = diff[SUM_W-1:0] + SUM_W'(rd_rsp.post);
    assign sum_sat = sum > SUM_W'(TOK_MAX);

    assign issue      = 32'(cnt_reg) < PLACE_COUNT;
    assign pass_end   = pend_reg && pend_last_reg;
    assign place_fail = pend_reg && (rd_rsp.pre != '0) && !rd_rsp.mark.omega && borrow;
    assign place_pom  = pend_reg && (rd_rsp.pre != '0) && rd_rsp.mark.omega;
    assign enabled    = !(fail_reg || place_fail);
    assign prop       = (rd_rsp.post != '0) && pomega_reg && omega_prop_reg;
    assign t_last     = 32'(t_reg) == TRANS_COUNT - 1;
    assign finish     = t_last || (enabled && (RES_W'(total_reg + 1'b1) == RES_W'(MAX_RES)));

    always_comb begin
        state_next       = state_reg;
        fire_mode_next   = fire_mode_reg;
        pl_ok_next       = pl_ok_reg;
        tr_field_next    = tr_field_reg;
        t_next           = t_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        pend_last_next   = 1'b0;
        proc_p_next      = proc_p_reg;
        fail_next        = fail_reg;
        pomega_next      = pomega_reg;
        sat_next         = sat_reg;
        held_vld_next    = held_vld_reg;
        held_t_next      = held_t_reg;
        total_next       = total_reg;
        fin_next         = fin_reg;
        after_lnext_next = after_lnext_reg;
        res_status_next  = res_status_reg;
        res_trans_next   = res_trans_reg;
        res_tokens_next  = res_tokens_reg;
        res_omega_next   = res_omega_reg;
        res_last_next    = res_last_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_trans_next     = m_trans_reg;
        m_tokens_next    = m_tokens_reg;
        m_omega_next     = m_omega_reg;
        m_last_next      = m_last_reg;

        rd_req.place     = cnt_reg[PLACE_W-1:0];
        rd_req.trans     = t_reg;
        wt_wr.pre_en     = 1'b0;
        wt_wr.post_en    = 1'b0;
        wt_wr.place      = PLACE_W'(s_place);
        wt_wr.trans      = TRANS_W'(s_trans);
        wt_wr.data       = s_value[WEIGHT_BITS-1:0];
        mk_wr.en         = 1'b0;
        mk_wr.place      = proc_p_reg;
        mk_wr.mark.omega = prop;
        mk_wr.mark.count = prop ? '0 : (sum_sat ? TOK_MAX : sum[TOKEN_BITS-1:0]);

        if ((state_reg == S_CHK) || (state_reg == S_UPD)) begin
            pend_next      = issue;
            pend_last_next = 32'(cnt_reg) == PLACE_COUNT - 1;
            proc_p_next    = cnt_reg[PLACE_W-1:0];
            if (issue) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                rd_req.place = PLACE_W'(s_place);
                if (s_tvalid && s_tready) begin
                    tr_field_next    = s_trans;
                    pl_ok_next       = s_pok;
                    cnt_next         = '0;
                    fail_next        = 1'b0;
                    pomega_next      = 1'b0;
                    sat_next         = 1'b0;
                    held_vld_next    = 1'b0;
                    total_next       = '0;
                    fin_next         = 1'b0;
                    after_lnext_next = 1'b0;
                    res_status_next  = STAT_OK;
                    res_trans_next   = s_trans;
                    res_tokens_next  = '0;
                    res_omega_next   = 1'b0;
                    res_last_next    = 1'b1;
                    unique case (s_kind) inside
                        KIND_PRE_WEIGHT, KIND_POST_WEIGHT: begin
                            wt_wr.pre_en  = (s_kind == KIND_PRE_WEIGHT) && s_pok && s_tok;
                            wt_wr.post_en = (s_kind == KIND_POST_WEIGHT) && s_pok && s_tok;
                            state_next    = S_EMIT;
                        end
                        KIND_SET_PLACE: begin
                            mk_wr.en         = s_pok;
                            mk_wr.place      = PLACE_W'(s_place);
                            mk_wr.mark.omega = s_som;
                            mk_wr.mark.count = s_som ? '0 :
                                               (set_sat ? TOK_MAX : TOKEN_BITS'(s_value));
                            if (s_pok && !s_som && set_sat) begin
                                res_status_next = STAT_SATURATED;
                            end
                            state_next = S_EMIT;
                        end
                        KIND_FIRE: begin
                            fire_mode_next = 1'b1;
                            t_next         = TRANS_W'(s_trans);
                            if (s_tok) begin
                                state_next = S_CHK;
                            end else begin
                                res_status_next = STAT_NOT_ENABLED;
                                state_next      = S_EMIT;
                            end
                        end
                        KIND_LIST: begin
                            fire_mode_next = 1'b0;
                            t_next         = '0;
                            state_next     = S_CHK;
                        end
                        KIND_READ_PLACE: begin
                            state_next = S_RDW;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHK: begin
                fail_next   = fail_reg | place_fail;
                pomega_next = pomega_reg | place_pom;
                if (pass_end) begin
                    if (fire_mode_reg) begin
                        if (enabled) begin
                            cnt_next   = '0;
                            sat_next   = 1'b0;
                            state_next = S_UPD;
                        end else begin
                            res_status_next = STAT_NOT_ENABLED;
                            state_next      = S_EMIT;
                        end
                    end else begin
                        fin_next = finish;
                        if (enabled) begin
                            total_next    = total_reg + 1'b1;
                            held_vld_next = 1'b1;
                            held_t_next   = t_reg;
                        end
                        if (enabled && held_vld_reg) begin
                            res_status_next  = STAT_OK;
                            res_trans_next   = 4'(held_t_reg);
                            res_tokens_next  = '0;
                            res_omega_next   = 1'b0;
                            res_last_next    = 1'b0;
                            after_lnext_next = 1'b1;
                            state_next       = S_EMIT;
                        end else begin
                            state_next = S_LNEXT;
                        end
                    end
                end
            end
            S_UPD: begin
                if (pend_reg && !rd_rsp.mark.omega) begin
                    mk_wr.en = 1'b1;
                    if (!prop && sum_sat) begin
                        sat_next = 1'b1;
                    end
                end
                if (pass_end) begin
                    if (sat_reg || (!rd_rsp.mark.omega && !prop && sum_sat)) begin
                        res_status_next = STAT_SATURATED;
                    end else begin
                        res_status_next = STAT_OK;
                    end
                    res_trans_next = tr_field_reg;
                    res_last_next  = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_RDW: begin
                res_status_next = STAT_OK;
                res_trans_next  = tr_field_reg;
                res_last_next   = 1'b1;
                if (pl_ok_reg && rd_rsp.mark.omega) begin
                    res_tokens_next = '0;
                    res_omega_next  = 1'b1;
                end else if (pl_ok_reg) begin
                    res_tokens_next = 16'(rd_rsp.mark.count);
                    res_omega_next  = 1'b0;
                end else begin
                    res_tokens_next = '0;
                    res_omega_next  = 1'b0;
                end
                state_next = S_EMIT;
            end
            S_LNEXT: begin
                if (fin_reg) begin
                    res_tokens_next  = '0;
                    res_omega_next   = 1'b0;
                    res_last_next    = 1'b1;
                    after_lnext_next = 1'b0;
                    if (held_vld_reg) begin
                        res_status_next = STAT_OK;
                        res_trans_next  = 4'(held_t_reg);
                    end else begin
                        res_status_next = STAT_NONE_ENABLED;
                        res_trans_next  = '0;
                    end
                    state_next = S_EMIT;
                end else begin
                    t_next     = t_reg + 1'b1;
                    cnt_next   = '0;
                    fail_next  = 1'b0;
                    state_next = S_CHK;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_trans_next  = res_trans_reg;
                    m_tokens_next = res_tokens_reg;
                    m_omega_next  = res_omega_reg;
                    m_last_next   = res_last_reg;
                    state_next    = after_lnext_reg ? S_LNEXT : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            omega_prop_reg  <= 1'b1;
            pend_reg        <= 1'b0;
            pend_last_reg   <= 1'b0;
            total_reg       <= '0;
            after_lnext_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_wr_en) begin
                omega_prop_reg <= cfg_wr_data;
            end
            pend_reg        <= pend_next;
            pend_last_reg   <= pend_last_next;
            total_reg       <= total_next;
            after_lnext_reg <= after_lnext_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        fire_mode_reg   <= fire_mode_next;
        pl_ok_reg       <= pl_ok_next;
        tr_field_reg    <= tr_field_next;
        t_reg           <= t_next;
        cnt_reg         <= cnt_next;
        proc_p_reg      <= proc_p_next;
        fail_reg        <= fail_next;
        pomega_reg      <= pomega_next;
        sat_reg         <= sat_next;
        held_vld_reg    <= held_vld_next;
        held_t_reg      <= held_t_next;
        fin_reg         <= fin_next;
        res_status_reg  <= res_status_next;
        res_trans_reg   <= res_trans_next;
        res_tokens_reg  <= res_tokens_next;
        res_omega_reg   <= res_omega_next;
        res_last_reg    <= res_last_next;
        m_status_reg    <= m_status_next;
        m_trans_reg     <= m_trans_next;
        m_tokens_reg    <= m_tokens_next;
        m_omega_reg     <= m_omega_next;
        m_last_reg      <= m_last_next;
    end

`ifndef SYNTHESIS
    a_pend_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> ((state_reg == S_CHK) || (state_reg == S_UPD)))
        else $error("place pipeline active outside a walk");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= RES_W'(MAX_RES))
        else $error("list result count beyond its limit");

    a_upd_no_borrow: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_UPD) && pend_reg && !rd_rsp.mark.omega) |-> !borrow)
        else $error("firing an enabled transition went below zero");

    a_mark_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mk_wr.en |-> ((state_reg == S_IDLE) || (state_reg == S_UPD)))
        else $error("marking written outside set or update");

    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_EMIT) && m_tvalid_reg && !m_tready) |=> (state_reg == S_EMIT))
        else $error("result left behind while the output word is stalled");
`endif

endmodule
